/* src/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("assertion failed");

`endif

/* src/gske_pkg.sv */
`timescale 1ns / 1ps

package gske_pkg;

    localparam int REPORT_KEYS = 24;
    localparam int BUTTON_KEYS = 14;

    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_STATE   = 2'd2;
    localparam logic [1:0] KIND_STROKE  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_NO_CONN = 2'd2;

    localparam int KEY_LT  = 14;
    localparam int KEY_RT  = 15;
    localparam int KEY_LXL = 16;
    localparam int KEY_LYU = 17;
    localparam int KEY_LXR = 18;
    localparam int KEY_LYD = 19;
    localparam int KEY_RXL = 20;
    localparam int KEY_RYU = 21;
    localparam int KEY_RXR = 22;
    localparam int KEY_RYD = 23;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 136;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    function automatic logic [15:0] button_bit(input int i);
        logic [15:0] b;
        begin
            case (i)
                0:       b = 16'h0004;
                1:       b = 16'h0001;
                2:       b = 16'h0008;
                3:       b = 16'h0002;
                4:       b = 16'h1000;
                5:       b = 16'h2000;
                6:       b = 16'h4000;
                7:       b = 16'h8000;
                8:       b = 16'h0020;
                9:       b = 16'h0010;
                10:      b = 16'h0100;
                11:      b = 16'h0200;
                12:      b = 16'h0040;
                13:      b = 16'h0080;
                default: b = 16'h0000;
            endcase
            return b;
        end
    endfunction

    function automatic logic [15:0] axis_of(input logic [15:0] lv, input logic neg);
        logic [15:0] mag;
        begin
            mag = lv[15] ? (16'h0000 - lv) : lv;
            if (lv == 16'h8000)
                mag = 16'h7FFF;
            return neg ? (16'h0000 - mag) : mag;
        end
    endfunction

    function automatic logic [7:0] trig_of(input logic [15:0] lv);
        logic [7:0] t;
        begin
            if (lv[15])
                t = 8'd0;
            else if (lv > 16'd255)
                t = 8'd255;
            else
                t = lv[7:0];
            return t;
        end
    endfunction

endpackage

/* src/gamepad_state_and_keystroke_engine_top.sv */
`timescale 1ns / 1ps
// A taken word is held in the capture registers, then its result goes to the output
// registers with m_tvalid; s_tready stays low until that table update and result load.
// The output register lets the next word in while a result waits, and a waiting
// result holds the following word in its update cycle.
// Reset: rst_n async, clears the key table, pending mask, packet counter and the
// output valid flag.

module gamepad_state_and_keystroke_engine_top
    import gske_pkg::*;
#(
    parameter int NUM_KEYS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // user[1:0], key_sel[6:2], pressed[7], key_value[23:8]
    input  logic [1:0]            s_tuser,   // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // pkt_count, buttons, trig_l,
                                             // trig_r, stick_lx, stick_ly, stick_rx,
                                             // stick_ry, stroke_key, stroke_flags
    output logic [1:0]            m_tuser    // status
);

    cmd_t cmd;

    gske_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    gske_dp #(
        .NUM_KEYS (NUM_KEYS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_kind    (s_tuser),
        .in_data    (s_tdata),
        .out_status (m_tuser),
        .out_data   (m_tdata)
    );

endmodule

/* src/gske_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gske_ctrl
    import gske_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    typedef enum logic {
        IDLE,
        BUSY
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign s_tready   = (state_reg == IDLE);
    assign m_tvalid   = out_valid_reg;
    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.commit  = (state_reg == BUSY) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (m_tready)
                        out_valid_reg <= 1'b0;
                    if (cmd.capture)
                        state_reg <= BUSY;
                end
                BUSY:
                begin
                    if (cmd.commit)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg     <= IDLE;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_capture_busy, clk, rst_n, cmd.capture, state_reg == BUSY && !s_tready)
    `ASSERT_NEXT(a_commit_out, clk, rst_n, cmd.commit, out_valid_reg && state_reg == IDLE)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

endmodule

/* src/gske_dp.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gske_dp
    import gske_pkg::*;
#(
    parameter int NUM_KEYS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [1:0]            in_kind,
    input  logic [IN_DATA_W-1:0]  in_data,
    output logic [1:0]            out_status,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam int KW = $clog2(NUM_KEYS);

    logic [1:0]  kind_reg;
    logic [1:0]  user_reg;
    logic [4:0]  idx_reg;
    logic        press_reg;
    logic [15:0] val_reg;

    logic [NUM_KEYS-1:0] down_reg, down_next;
    logic [NUM_KEYS-1:0] before_reg, before_next;
    logic [NUM_KEYS-1:0] pend_reg, pend_next;
    logic [15:0]         level_reg [NUM_KEYS];
    logic [15:0]         level_next [NUM_KEYS];
    logic [31:0]         count_reg, count_next;

    logic [1:0]  status_reg, status_next;
    logic [31:0] packet_reg, packet_next;
    logic [15:0] buttons_reg, buttons_next;
    logic [7:0]  lt_reg, lt_next, rt_reg, rt_next;
    logic [15:0] lx_reg, lx_next, ly_reg, ly_next, rx_reg, rx_next, ry_reg, ry_next;
    logic [4:0]  skey_reg, skey_next;
    logic [2:0]  sflags_reg, sflags_next;

    logic          found;
    logic [KW-1:0] pidx;
    logic [KW-1:0] ki;

    assign ki = idx_reg[KW-1:0];

    always_comb
    begin
        found = 1'b0;
        pidx  = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                found = 1'b1;
                pidx  = KW'(i);
            end
        end
    end

    always_comb
    begin
        down_next   = down_reg;
        before_next = before_reg;
        pend_next   = pend_reg;
        level_next  = level_reg;
        count_next  = count_reg;
        status_next  = ST_OK;
        packet_next  = '0;
        buttons_next = '0;
        lt_next = '0;
        rt_next = '0;
        lx_next = '0;
        ly_next = '0;
        rx_next = '0;
        ry_next = '0;
        skey_next   = '0;
        sflags_next = '0;
        case (kind_reg)
            KIND_KEY:
            begin
                if ({1'b0, idx_reg} < 6'(NUM_KEYS))
                begin
                    before_next[ki] = down_reg[ki];
                    down_next[ki]   = press_reg;
                    level_next[ki]  = val_reg;
                    if (down_reg[ki] != press_reg)
                        pend_next[ki] = 1'b1;
                end
            end
            KIND_RELEASE:
            begin
                for (int i = 0; i < NUM_KEYS; i++)
                begin
                    if (down_reg[i])
                    begin
                        before_next[i] = 1'b1;
                        down_next[i]   = 1'b0;
                        level_next[i]  = '0;
                        pend_next[i]   = 1'b1;
                    end
                end
            end
            KIND_STATE:
            begin
                if (user_reg != 2'd0)
                    status_next = ST_NO_CONN;
                else
                begin
                    count_next  = count_reg + 32'd1;
                    packet_next = count_next;
                    for (int i = 0; i < BUTTON_KEYS; i++)
                    begin
                        if (down_reg[i])
                            buttons_next = buttons_next | button_bit(i);
                    end
                    if (down_reg[KEY_LT])
                        lt_next = trig_of(level_reg[KEY_LT]);
                    if (down_reg[KEY_RT])
                        rt_next = trig_of(level_reg[KEY_RT]);
                    if (down_reg[KEY_LXR])
                        lx_next = axis_of(level_reg[KEY_LXR], 1'b0);
                    else if (down_reg[KEY_LXL])
                        lx_next = axis_of(level_reg[KEY_LXL], 1'b1);
                    if (down_reg[KEY_LYD])
                        ly_next = axis_of(level_reg[KEY_LYD], 1'b1);
                    else if (down_reg[KEY_LYU])
                        ly_next = axis_of(level_reg[KEY_LYU], 1'b0);
                    if (down_reg[KEY_RXR])
                        rx_next = axis_of(level_reg[KEY_RXR], 1'b0);
                    else if (down_reg[KEY_RXL])
                        rx_next = axis_of(level_reg[KEY_RXL], 1'b1);
                    if (down_reg[KEY_RYD])
                        ry_next = axis_of(level_reg[KEY_RYD], 1'b1);
                    else if (down_reg[KEY_RYU])
                        ry_next = axis_of(level_reg[KEY_RYU], 1'b0);
                end
            end
            KIND_STROKE:
            begin
                if (user_reg != 2'd0)
                    status_next = ST_NO_CONN;
                else if (found)
                begin
                    pend_next[pidx] = 1'b0;
                    skey_next   = 5'(pidx);
                    sflags_next = {before_reg[pidx] == down_reg[pidx],
                                   !down_reg[pidx], down_reg[pidx]};
                end
                else
                    status_next = ST_EMPTY;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= in_kind;
            user_reg  <= in_data[1:0];
            idx_reg   <= in_data[6:2];
            press_reg <= in_data[7];
            val_reg   <= in_data[23:8];
        end
        if (cmd.commit)
        begin
            status_reg  <= status_next;
            packet_reg  <= packet_next;
            buttons_reg <= buttons_next;
            lt_reg      <= lt_next;
            rt_reg      <= rt_next;
            lx_reg      <= lx_next;
            ly_reg      <= ly_next;
            rx_reg      <= rx_next;
            ry_reg      <= ry_next;
            skey_reg    <= skey_next;
            sflags_reg  <= sflags_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg   <= '0;
            before_reg <= '0;
            pend_reg   <= '0;
            count_reg  <= '0;
            for (int i = 0; i < NUM_KEYS; i++)
                level_reg[i] <= '0;
        end
        else if (cmd.commit)
        begin
            down_reg   <= down_next;
            before_reg <= before_next;
            pend_reg   <= pend_next;
            count_reg  <= count_next;
            level_reg  <= level_next;
        end
    end

    assign out_status = status_reg;
    assign out_data   = {sflags_reg, skey_reg, ry_reg, rx_reg, ly_reg, lx_reg,
                         rt_reg, lt_reg, buttons_reg, packet_reg};

    `ASSERT_NEXT(a_release_clears, clk, rst_n, cmd.commit && kind_reg == KIND_RELEASE, !(|down_reg))
    `ASSERT_NEXT(a_count_hold, clk, rst_n, cmd.commit && kind_reg != KIND_STATE, count_reg == $past(count_reg))
    `ASSERT_IMPL(a_key_status, clk, rst_n, cmd.commit && kind_reg == KIND_KEY, status_next == ST_OK)

endmodule
